// ----- rtl/sparse_polynomial_multiply_macros.svh -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiply assertion macros
// Shared assertion forms for the sparse polynomial multiply modules.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_MULTIPLY_MACROS_SVH
`define SPARSE_POLYNOMIAL_MULTIPLY_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/spm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiply package
// Widths, item codes and the command type passed from front to back.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int MaxTerms    = 8;
  localparam int CoefWidth   = 16;
  localparam int DegreeWidth = 8;

  localparam int InCoefW   = 16;
  localparam int InDegW    = 8;
  localparam int OutCoefW  = 38;
  localparam int OutDegW   = 9;
  localparam int IdxW      = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int CntW      = $clog2(MaxTerms + 1);
  localparam int ProdDepth = MaxTerms * MaxTerms;
  localparam int MIdxW     = (ProdDepth > 1) ? $clog2(ProdDepth) : 1;
  localparam int MCntW     = $clog2(ProdDepth + 1);
  localparam int SumDegW   = DegreeWidth + 1;
  localparam int ProdW     = 2 * CoefWidth;
  localparam int CmdQDepth = 2;

  localparam logic [1:0] KindLoadFirst  = 2'd0;
  localparam logic [1:0] KindLoadSecond = 2'd1;
  localparam logic [1:0] KindCompute    = 2'd2;

  typedef struct packed {
    logic            load_sel;
    logic            is_compute;
    logic [CoefWidth-1:0]   coef;
    logic [DegreeWidth-1:0] degree;
  } cmd_t;

endpackage

// ----- rtl/spm_front.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiply front end
// Accepts items, drops unused codes and passes commands to a short queue.
// ----------------------------------------------------------------------------
module spm_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  kind_i,
  input  logic [spm_pkg::InCoefW-1:0] term_coef_i,
  input  logic [spm_pkg::InDegW-1:0]  term_degree_i,
  output logic                        cmd_valid_o,
  output spm_pkg::cmd_t               cmd_o,
  input  logic                        cmd_ready_i
);
  import spm_pkg::*;

  localparam int QIdxW = $clog2(CmdQDepth);

  cmd_t            q_mem [CmdQDepth];
  logic [QIdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QIdxW:0]   cnt_q, cnt_d;
  logic            acc, useful, deq;
  cmd_t            cmd_in;

  assign full   = (cnt_q == (QIdxW+1)'(CmdQDepth));
  assign acc    = push && !full;
  assign useful = (kind_i == KindLoadFirst) || (kind_i == KindLoadSecond) ||
                  (kind_i == KindCompute);
  assign deq    = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o  = q_mem[rd_q];

  always_comb begin
    cmd_in.load_sel   = (kind_i == KindLoadSecond);
    cmd_in.is_compute = (kind_i == KindCompute);
    cmd_in.coef       = term_coef_i[CoefWidth-1:0];
    cmd_in.degree     = term_degree_i[DegreeWidth-1:0];
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (acc && useful) begin
      wr_d = (wr_q == QIdxW'(CmdQDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (deq) begin
      rd_d = (rd_q == QIdxW'(CmdQDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (QIdxW+1)'(acc && useful) - (QIdxW+1)'(deq);
  end

  always_ff @(posedge clk_i) begin
    if (acc && useful) begin
      q_mem[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`include "sparse_polynomial_multiply_macros.svh"

  `SPM_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= (QIdxW+1)'(CmdQDepth), "queue overfull")
  `SPM_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, acc && useful && !deq, cnt_q == $past(cnt_q) + 1'b1, "queue count slip")
  `SPM_ASSERT_NEXT(a_ignore, clk_i, rst_ni, acc && !useful && !deq, $stable(cnt_q), "unused code queued")

endmodule

// ----- rtl/spm_back.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiply back end
// Stores terms, forms and merges products, and queues the result items.
// ----------------------------------------------------------------------------
module spm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  spm_pkg::cmd_t                cmd_i,
  output logic                         cmd_ready_o,
  output logic                         empty,
  input  logic                         pop,
  output logic [spm_pkg::OutCoefW-1:0] out_coef_o,
  output logic [spm_pkg::OutDegW-1:0]  out_degree_o,
  output logic                         is_last_o,
  output logic                         is_empty_o,
  output logic                         load_overflow_o
);
  import spm_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StRead, StMul, StScan, StEmit, StEmitWait
  } state_e;

  logic signed [CoefWidth-1:0] a_coef [MaxTerms];
  logic [DegreeWidth-1:0]      a_deg  [MaxTerms];
  logic signed [CoefWidth-1:0] b_coef [MaxTerms];
  logic [DegreeWidth-1:0]      b_deg  [MaxTerms];
  logic signed [OutCoefW-1:0]  m_coef [ProdDepth];
  logic [SumDegW-1:0]          m_deg  [ProdDepth];

  state_e               st_q;
  logic [CntW-1:0]      acnt_q, bcnt_q;
  logic                 ovf_q, ovf_snap_q;
  logic [IdxW-1:0]      ai_q, bi_q;
  logic [MCntW-1:0]     mcnt_q, k_q;
  logic signed [CoefWidth-1:0] ca_q, cb_q;
  logic [SumDegW-1:0]   d_q;
  logic signed [ProdW-1:0] p_q;
  logic [SumDegW-1:0]   rd_deg_q;
  logic signed [OutCoefW-1:0] rd_coef_q;
  logic                 rd_vld_q;

  // Result register, one item deep.
  logic                 ovalid_q;
  logic signed [OutCoefW-1:0] ocoef_q;
  logic [OutDegW-1:0]   odeg_q;
  logic                 olast_q, oempty_q, oovf_q;

  logic                 oslot_free, last_pair, hit;
  logic [MIdxW-1:0]     k_idx;

  assign empty           = !ovalid_q;
  assign out_coef_o      = ocoef_q;
  assign out_degree_o    = odeg_q;
  assign is_last_o       = olast_q;
  assign is_empty_o      = oempty_q;
  assign load_overflow_o = oovf_q;
  assign oslot_free      = !ovalid_q || pop;
  assign cmd_ready_o     = (st_q == StIdle) &&
                           (!cmd_i.is_compute || oslot_free || (acnt_q != '0 && bcnt_q != '0));
  assign last_pair = ({1'b0, ai_q} == CntW'(acnt_q - 1'b1)) &&
                     ({1'b0, bi_q} == CntW'(bcnt_q - 1'b1));
  assign k_idx     = k_q[MIdxW-1:0];
  assign hit       = rd_vld_q && (k_q != '0) && (rd_deg_q == d_q);

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && cmd_valid_i && cmd_ready_o && !cmd_i.is_compute) begin
      if (!cmd_i.load_sel && acnt_q < CntW'(MaxTerms)) begin
        a_coef[acnt_q[IdxW-1:0]] <= cmd_i.coef;
        a_deg[acnt_q[IdxW-1:0]]  <= cmd_i.degree;
      end
      if (cmd_i.load_sel && bcnt_q < CntW'(MaxTerms)) begin
        b_coef[bcnt_q[IdxW-1:0]] <= cmd_i.coef;
        b_deg[bcnt_q[IdxW-1:0]]  <= cmd_i.degree;
      end
    end
    ca_q <= a_coef[ai_q];
    cb_q <= b_coef[bi_q];
    if (st_q == StRead) begin
      d_q <= SumDegW'(a_deg[ai_q]) + SumDegW'(b_deg[bi_q]);
    end
    if (st_q == StMul) begin
      p_q <= ca_q * cb_q;
    end
    rd_deg_q  <= m_deg[k_idx];
    rd_coef_q <= m_coef[k_idx];
    if (st_q == StScan && hit) begin
      m_coef[k_idx - 1'b1] <= rd_coef_q + OutCoefW'(p_q);
    end else if (st_q == StScan && rd_vld_q && k_q >= mcnt_q) begin
      m_coef[mcnt_q[MIdxW-1:0]] <= OutCoefW'(p_q);
      m_deg[mcnt_q[MIdxW-1:0]]  <= d_q;
    end
  end

  // The scan reads entry k into a register and compares it in the next cycle; k_q points one past.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; acnt_q <= '0; bcnt_q <= '0; ovf_q <= 1'b0; ovf_snap_q <= 1'b0;
      ai_q <= '0; bi_q <= '0; mcnt_q <= '0; k_q <= '0; rd_vld_q <= 1'b0;
      ovalid_q <= 1'b0; ocoef_q <= '0; odeg_q <= '0;
      olast_q <= 1'b0; oempty_q <= 1'b0; oovf_q <= 1'b0;
    end else begin
      if (pop && ovalid_q) begin
        ovalid_q <= 1'b0;
      end
      case (st_q)
        StIdle: begin
          if (cmd_valid_i && cmd_ready_o) begin
            if (!cmd_i.is_compute) begin
              if (!cmd_i.load_sel) begin
                if (acnt_q < CntW'(MaxTerms)) acnt_q <= acnt_q + 1'b1;
                else ovf_q <= 1'b1;
              end else begin
                if (bcnt_q < CntW'(MaxTerms)) bcnt_q <= bcnt_q + 1'b1;
                else ovf_q <= 1'b1;
              end
            end else if (acnt_q == '0 || bcnt_q == '0) begin
              ovalid_q <= 1'b1; ocoef_q <= '0; odeg_q <= '0;
              olast_q <= 1'b1; oempty_q <= 1'b1; oovf_q <= ovf_q;
              acnt_q <= '0; bcnt_q <= '0; ovf_q <= 1'b0;
            end else begin
              ovf_snap_q <= ovf_q;
              ai_q <= '0; bi_q <= '0; mcnt_q <= '0;
              st_q <= StRead;
            end
          end
        end
        StRead: begin
          st_q <= StMul;
        end
        StMul: begin
          k_q <= '0; rd_vld_q <= 1'b0;
          st_q <= StScan;
        end
        StScan: begin
          if (hit || (rd_vld_q && k_q >= mcnt_q)) begin
            if (!hit) begin
              mcnt_q <= mcnt_q + 1'b1;
            end
            rd_vld_q <= 1'b0;
            if (last_pair) begin
              k_q <= '0;
              st_q <= StEmitWait;
            end else begin
              if ({1'b0, bi_q} == CntW'(bcnt_q - 1'b1)) begin
                bi_q <= '0; ai_q <= ai_q + 1'b1;
              end else begin
                bi_q <= bi_q + 1'b1;
              end
              st_q <= StRead;
            end
          end else if (!rd_vld_q && mcnt_q == '0) begin
            rd_vld_q <= 1'b1;
          end else begin
            rd_vld_q <= 1'b1;
            k_q <= k_q + 1'b1;
          end
        end
        StEmitWait: begin
          st_q <= StEmit;
        end
        StEmit: begin
          if (oslot_free) begin
            ovalid_q <= 1'b1;
            ocoef_q  <= rd_coef_q;
            odeg_q   <= OutDegW'(rd_deg_q);
            olast_q  <= (k_q == mcnt_q - 1'b1);
            oempty_q <= 1'b0;
            oovf_q   <= ovf_snap_q;
            if (k_q == mcnt_q - 1'b1) begin
              acnt_q <= '0; bcnt_q <= '0; ovf_q <= 1'b0;
              st_q <= StIdle;
            end else begin
              k_q <= k_q + 1'b1;
              st_q <= StEmitWait;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

`include "sparse_polynomial_multiply_macros.svh"

  `SPM_ASSERT_IMP(a_mcnt_bound, clk_i, rst_ni, 1'b1, mcnt_q <= MCntW'(ProdDepth), "merge count too big")
  `SPM_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, acnt_q <= CntW'(MaxTerms) && bcnt_q <= CntW'(MaxTerms), "term count too big")
  `SPM_ASSERT_NEXT(a_hold, clk_i, rst_ni, ovalid_q && !pop, ovalid_q && $stable(ocoef_q), "result lost")

endmodule

// ----- rtl/sparse_polynomial_multiply.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiply
// Loads two sparse polynomials term by term and emits their merged product.
// ----------------------------------------------------------------------------
// A load item is stored from the idle state of the back end. A compute item
// walks every product pair in turn through the read, multiply and scan states;
// the scan compares the product's degree with each distinct degree already
// found, one entry at a time since the merge store has one read port, and each
// result item then passes through the emit-wait and emit states. A two-entry
// command queue lets items be pushed while a compute is running.
module sparse_polynomial_multiply (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   kind_i,
  input  logic [spm_pkg::InCoefW-1:0]  term_coef_i,
  input  logic [spm_pkg::InDegW-1:0]   term_degree_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [spm_pkg::OutCoefW-1:0] out_coef_o,
  output logic [spm_pkg::OutDegW-1:0]  out_degree_o,
  output logic                         is_last_o,
  output logic                         is_empty_o,
  output logic                         load_overflow_o
);
  import spm_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  spm_front u_front (
    .clk_i, .rst_ni, .push, .full, .kind_i, .term_coef_i, .term_degree_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  spm_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .empty, .pop, .out_coef_o, .out_degree_o, .is_last_o, .is_empty_o,
    .load_overflow_o
  );

endmodule

// ----- sim/sparse_polynomial_multiply_test.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiply regression
// Loads term pairs into both stores and requests products, with random
// gaps on the push side and random stalls on the pop side. Every popped
// item is compared with a software product of the loaded polynomials.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_polynomial_multiply_test;
  import spm_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int RandomItems = 290;
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 400;

  typedef struct packed {
    logic [OutCoefW-1:0] coef;
    logic [OutDegW-1:0]  degree;
    logic                last;
    logic                empt;
    logic                ovf;
  } term_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] coef;
    logic [7:0]  degree;
    bit          typed;
    bit          ovf;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] kind_i = '0;
  logic [InCoefW-1:0] term_coef_i = '0;
  logic [InDegW-1:0] term_degree_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [OutCoefW-1:0] out_coef_o;
  logic [OutDegW-1:0] out_degree_o;
  logic is_last_o;
  logic is_empty_o;
  logic load_overflow_o;

  term_t product_q[$];
  int errors = 0;
  int accepted = 0;
  int cycle = 0;

  logic signed [15:0] first_c[MaxTerms];
  logic [7:0] first_d[MaxTerms];
  logic signed [15:0] second_c[MaxTerms];
  logic [7:0] second_d[MaxTerms];
  int first_n = 0;
  int second_n = 0;
  bit dropped = 1'b0;

  sparse_polynomial_multiply u_dut (
    .clk_i, .rst_ni, .push, .full, .kind_i, .term_coef_i, .term_degree_i,
    .empty, .pop, .out_coef_o, .out_degree_o, .is_last_o, .is_empty_o,
    .load_overflow_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("sparse_polynomial_multiply regression: fail");
      $finish;
    end
  end

  // Runs one item through the software model and queues its products when keep is set.
  task automatic apply_item(input logic [1:0] kind, input logic [15:0] coef,
                            input logic [7:0] degree, input bit keep);
    longint mc[ProdDepth];
    logic [8:0] md[ProdDepth];
    int mn;
    int k;
    bit hit;
    longint c;
    logic [8:0] d;
    term_t t;
    mn = 0;
    if (kind == KindLoadFirst || kind == KindLoadSecond) begin
      if (kind == KindLoadFirst && first_n < MaxTerms) begin
        first_c[first_n] = coef;
        first_d[first_n] = degree;
        first_n++;
      end else if (kind == KindLoadSecond && second_n < MaxTerms) begin
        second_c[second_n] = coef;
        second_d[second_n] = degree;
        second_n++;
      end else begin
        dropped = 1'b1;
      end
    end else if (kind == KindCompute) begin
      if (first_n == 0 || second_n == 0) begin
        t = '{coef: '0, degree: '0, last: 1'b1, empt: 1'b1, ovf: dropped};
        if (keep) product_q.push_back(t);
      end else begin
        for (int a = 0; a < first_n; a++) begin
          for (int b = 0; b < second_n; b++) begin
            c = longint'(first_c[a]) * longint'(second_c[b]);
            d = {1'b0, first_d[a]} + {1'b0, second_d[b]};
            hit = 1'b0;
            for (k = 0; k < mn && !hit; k++) begin
              if (md[k] == d) begin
                mc[k] += c;
                hit = 1'b1;
              end
            end
            if (!hit) begin
              mc[mn] = c;
              md[mn] = d;
              mn++;
            end
          end
        end
        for (k = 0; k < mn; k++) begin
          t = '{coef: mc[k][OutCoefW-1:0], degree: md[k], last: (k == mn - 1),
                empt: 1'b0, ovf: dropped};
          if (keep) product_q.push_back(t);
        end
      end
      first_n = 0;
      second_n = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic send(input logic [1:0] kind, input logic [15:0] coef,
                      input logic [7:0] degree);
    int gap;
    push <= 1'b1;
    kind_i <= kind;
    term_coef_i <= coef;
    term_degree_i <= degree;
    do @(posedge clk_i); while (full);
    accepted++;
    apply_item(kind, coef, degree, 1'b1);
    gap = $urandom_range(0, 99);
    if (gap >= 60) begin
      push <= 1'b0;
      repeat (gap < 95 ? $urandom_range(1, 3) : $urandom_range(20, 80))
        @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    bit hold_done;
    int hold_left;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && accepted >= 120) begin
        hold_done = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (cycle % 2000 < 300) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) == 0 && 1'b0);
      end
    end
  end

  always @(posedge clk_i) begin
    term_t t;
    if (rst_ni && pop && !empty) begin
      if (product_q.size() == 0) begin
        $error("unexpected item: coef %h degree %0d", out_coef_o, out_degree_o);
        errors++;
      end else begin
        t = product_q.pop_front();
        if (out_coef_o !== t.coef) begin
          $error("out_coef expected %h actual %h", t.coef, out_coef_o);
          errors++;
        end
        if (out_degree_o !== t.degree) begin
          $error("out_degree expected %0d actual %0d", t.degree, out_degree_o);
          errors++;
        end
        if (is_last_o !== t.last) begin
          $error("is_last expected %0d actual %0d", t.last, is_last_o);
          errors++;
        end
        if (is_empty_o !== t.empt) begin
          $error("is_empty expected %0d actual %0d", t.empt, is_empty_o);
          errors++;
        end
        if (load_overflow_o !== t.ovf) begin
          $error("load_overflow expected %0d actual %0d", t.ovf, load_overflow_o);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    int n1;
    int n2;
    int span;
    int sent;
    int wait_n;
    bit paused;
    term_t t;
    rows.push_back('{KindCompute, 16'h0, 8'h0, 1'b1, 1'b0});
    rows.push_back('{KindLoadFirst, 16'h8000, 8'hff, 1'b0, 1'b0});
    rows.push_back('{KindLoadSecond, 16'h8000, 8'hff, 1'b0, 1'b0});
    rows.push_back('{KindCompute, 16'h0, 8'h0, 1'b0, 1'b0});
    rows.push_back('{KindUnused, 16'h1234, 8'h56, 1'b0, 1'b0});
    for (int i = 0; i < MaxTerms + 1; i++)
      rows.push_back('{KindLoadFirst, 16'(i * 4099), 8'(i * 29), 1'b0, 1'b0});
    rows.push_back('{KindCompute, 16'h0, 8'h0, 1'b1, 1'b1});
    rows.push_back('{KindLoadFirst, 16'h7fff, 8'h00, 1'b0, 1'b0});
    rows.push_back('{KindLoadSecond, 16'h7fff, 8'h00, 1'b0, 1'b0});
    rows.push_back('{KindLoadSecond, 16'hffff, 8'h00, 1'b0, 1'b0});
    rows.push_back('{KindLoadSecond, 16'h0001, 8'h01, 1'b0, 1'b0});
    rows.push_back('{KindCompute, 16'h0, 8'h0, 1'b0, 1'b0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        t = '{coef: '0, degree: '0, last: 1'b1, empt: 1'b1, ovf: rows[i].ovf};
        push <= 1'b1;
        kind_i <= rows[i].kind;
        term_coef_i <= rows[i].coef;
        term_degree_i <= rows[i].degree;
        do @(posedge clk_i); while (full);
        accepted++;
        product_q.push_back(t);
        apply_item(rows[i].kind, rows[i].coef, rows[i].degree, 1'b0);
      end else begin
        send(rows[i].kind, rows[i].coef, rows[i].degree);
      end
    end

    sent = 0;
    paused = 1'b0;
    while (sent < RandomItems) begin
      if (!paused && sent >= 200) begin
        paused = 1'b1;
        push <= 1'b0;
        while (product_q.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 9) == 0) begin
        send($urandom_range(0, 9) == 0 ? KindUnused : 2'($urandom_range(0, 2)),
             16'($urandom), 8'($urandom));
        sent++;
      end else begin
        n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 4);
        n2 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 4);
        span = ($urandom_range(0, 1) == 0) ? 3 : 255;
        for (int i = 0; i < n1 + n2; i++) begin
          if (n1 > i && n2 > i - n1 && $urandom_range(0, 1) == 0 && i < n1)
            send(KindLoadFirst, pick_coef(), 8'($urandom_range(0, span)));
          else if (i < n1)
            send(KindLoadFirst, pick_coef(), 8'($urandom_range(0, span)));
          else
            send(KindLoadSecond, pick_coef(), 8'($urandom_range(0, span)));
        end
        send(KindCompute, 16'($urandom), 8'($urandom));
        sent += n1 + n2 + 1;
      end
    end
    push <= 1'b0;

    while (product_q.size() != 0) @(posedge clk_i);
    wait_n = 0;
    while (wait_n < DrainCycles) begin
      @(posedge clk_i);
      wait_n++;
    end
    if (errors == 0 && product_q.size() == 0) begin
      $display("sparse_polynomial_multiply regression: pass");
    end else begin
      $display("sparse_polynomial_multiply regression: fail");
    end
    $finish;
  end

endmodule
